[rtl/core/cgvs_pkg.sv]
package cgvs_pkg;

  typedef enum logic [1:0] {
    KIND_UPDATE  = 2'd0,
    KIND_CONTROL = 2'd1,
    KIND_STOP    = 2'd2,
    KIND_START   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_ALPHA   = 2'd0,
    REG_GAIN    = 2'd1,
    REG_SCALE   = 2'd2,
    REG_TIMEOUT = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_MUL_DECAY,
    OP_MUL_GAIN,
    OP_SUM,
    OP_MUL_SCALE,
    OP_CMD,
    OP_STOP
  } dp_op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECAY,
    S_GAIN,
    S_SUM,
    S_SCALE,
    S_CMD,
    S_STOP,
    S_PUSH
  } state_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] axis;
    logic       accept;
    logic       push;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_stat_t;

  typedef struct packed {
    logic [15:0] alpha;
    logic [23:0] gain;
    logic [15:0] scale;
    logic [15:0] timeout;
  } cfg_t;

  localparam logic [15:0] ALPHA_RST   = 16'd65208;
  localparam logic [23:0] GAIN_RST    = 24'd6291;
  localparam logic [15:0] SCALE_RST   = 16'd46341;
  localparam logic [15:0] TIMEOUT_RST = 16'd2000;

  localparam int          AXES      = 3;
  localparam logic [1:0]  LAST_AXIS = 2'd2;
  localparam int          IN_W      = 200;
  localparam int          OUT_W     = 96;
  localparam int          CFG_W     = 24;
  localparam int          MUL_A_W   = 25;

  // s_tdata field offsets
  localparam int TGT_LSB     = 0;
  localparam int CONTACT_LSB = 96;
  localparam int COLL_BIT    = 99;
  localparam int DES_LSB     = 100;

endpackage

[rtl/core/cgvs_ctrl.sv]
module cgvs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  cgvs_pkg::kind_t    in_kind,
  output logic               in_ready,
  input  cgvs_pkg::dp_stat_t stat,
  output cgvs_pkg::dp_cmd_t  cmd
);

  cgvs_pkg::state_t state, state_next;
  logic [1:0]       axis, axis_next;
  logic             stop, stop_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cgvs_pkg::S_IDLE;
      axis  <= '0;
      stop  <= 1'b0;
    end else begin
      state <= state_next;
      axis  <= axis_next;
      stop  <= stop_next;
    end
  end

  always_comb begin
    state_next = state;
    axis_next  = axis;
    stop_next  = stop;
    in_ready   = 1'b0;
    cmd.op     = cgvs_pkg::OP_NONE;
    cmd.axis   = axis;
    cmd.accept = 1'b0;
    cmd.push   = 1'b0;
    unique case (state)
      cgvs_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (in_kind == cgvs_pkg::KIND_CONTROL || in_kind == cgvs_pkg::KIND_STOP) begin
            state_next = cgvs_pkg::S_DECAY;
            axis_next  = '0;
            stop_next  = (in_kind == cgvs_pkg::KIND_STOP);
          end
        end
      end
      cgvs_pkg::S_DECAY: begin
        cmd.op     = cgvs_pkg::OP_MUL_DECAY;
        state_next = stop ? cgvs_pkg::S_STOP : cgvs_pkg::S_GAIN;
      end
      cgvs_pkg::S_GAIN: begin
        cmd.op     = cgvs_pkg::OP_MUL_GAIN;
        state_next = cgvs_pkg::S_SUM;
      end
      cgvs_pkg::S_SUM: begin
        cmd.op     = cgvs_pkg::OP_SUM;
        state_next = cgvs_pkg::S_SCALE;
      end
      cgvs_pkg::S_SCALE: begin
        cmd.op     = cgvs_pkg::OP_MUL_SCALE;
        state_next = cgvs_pkg::S_CMD;
      end
      cgvs_pkg::S_CMD, cgvs_pkg::S_STOP: begin
        cmd.op = (state == cgvs_pkg::S_CMD) ? cgvs_pkg::OP_CMD : cgvs_pkg::OP_STOP;
        if (axis == cgvs_pkg::LAST_AXIS) begin
          state_next = cgvs_pkg::S_PUSH;
        end else begin
          axis_next  = axis + 2'd1;
          state_next = cgvs_pkg::S_DECAY;
        end
      end
      cgvs_pkg::S_PUSH: begin
        if (stat.out_free) begin
          cmd.push   = 1'b1;
          state_next = cgvs_pkg::S_IDLE;
        end
      end
      default: state_next = cgvs_pkg::S_IDLE;
    endcase
  end

endmodule

[rtl/core/cgvs_dp.sv]
module cgvs_dp #(
  parameter int VEL_WIDTH = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  cgvs_pkg::cfg_t              cfg,
  input  cgvs_pkg::dp_cmd_t           cmd,
  input  cgvs_pkg::kind_t             in_kind,
  input  logic [cgvs_pkg::IN_W-1:0]   in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cgvs_pkg::OUT_W-1:0]  out_data,
  output cgvs_pkg::dp_stat_t          stat
);

  localparam int W  = VEL_WIDTH;
  localparam int OW = (W > 32) ? W : 32;
  localparam int SW = OW + 1;
  localparam int PW = cgvs_pkg::MUL_A_W + OW;

  localparam logic signed [PW-1:0] HALF16 = PW'(32768);
  localparam logic signed [PW-1:0] HALF24 = PW'(8388608);
  localparam logic [W-1:0]         MIN_W  = W'(1) << (W - 1);
  localparam logic [W-1:0]         MAX_W  = ~MIN_W;

  logic signed [W-1:0]  filt  [cgvs_pkg::AXES];
  logic signed [31:0]   tgt   [cgvs_pkg::AXES];
  logic signed [31:0]   cause [cgvs_pkg::AXES];
  logic [31:0]          work  [cgvs_pkg::AXES];
  logic [2:0]           contact;
  logic                 collide;
  logic                 prev_contact;
  logic [15:0]          idle_ticks;
  logic signed [W-1:0]  a_reg;
  logic signed [PW-1:0] prod;

  logic [2:0]                        in_contact;
  logic                              in_any;
  logic [15:0]                       idle_inc;
  logic signed [cgvs_pkg::MUL_A_W-1:0] mul_a;
  logic signed [OW-1:0]              mul_b;
  logic signed [PW-1:0]              r16, r24;
  logic signed [W-1:0]               r16_w;
  logic signed [OW-1:0]              r16_o;
  logic signed [31:0]                g;
  logic signed [SW-1:0]              sum;
  logic [W-1:0]                      sum_sat;
  logic [31:0]                       cmd_val;
  logic                              gate;
  logic signed [31:0]                t_cur, c_cur;

  assign in_contact = in_data[cgvs_pkg::CONTACT_LSB +: 3];
  assign in_any     = |in_contact;
  assign idle_inc   = (idle_ticks == 16'hFFFF) ? idle_ticks : idle_ticks + 16'd1;

  // same-sign test between target and latched cause, zero never gates
  assign t_cur = tgt[cmd.axis];
  assign c_cur = cause[cmd.axis];
  assign gate  = contact[cmd.axis] && (t_cur != 32'sd0) && (c_cur != 32'sd0)
                 && (t_cur[31] == c_cur[31]);

  always_comb begin
    case (cmd.op)
      cgvs_pkg::OP_MUL_GAIN: begin
        mul_a = $signed({1'b0, cfg.gain});
        mul_b = gate ? '0 : OW'(t_cur);
      end
      cgvs_pkg::OP_MUL_SCALE: begin
        mul_a = $signed({9'd0, cfg.scale});
        mul_b = OW'(filt[cmd.axis]);
      end
      default: begin
        mul_a = $signed({9'd0, cfg.alpha});
        mul_b = OW'(filt[cmd.axis]);
      end
    endcase
  end

  // round half up, then floor
  assign r16   = (prod + HALF16) >>> 16;
  assign r24   = (prod + HALF24) >>> 24;
  assign r16_w = r16[W-1:0];
  assign r16_o = OW'(r16_w);
  assign g     = r24[31:0];
  assign sum   = SW'(a_reg) + SW'(g);

  always_comb begin
    if (sum[SW-1:W-1] != {(SW-W+1){sum[SW-1]}}) begin
      sum_sat = sum[SW-1] ? MIN_W : MAX_W;
    end else begin
      sum_sat = sum[W-1:0];
    end
    if (r16_o[OW-1:31] != {(OW-31){r16_o[OW-1]}}) begin
      cmd_val = r16_o[OW-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end else begin
      cmd_val = r16_o[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cgvs_pkg::AXES; i++) begin
        filt[i]  <= '0;
        tgt[i]   <= '0;
        cause[i] <= '0;
      end
      prev_contact <= 1'b0;
      idle_ticks   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cmd.accept) begin
        case (in_kind)
          cgvs_pkg::KIND_UPDATE: begin
            for (int i = 0; i < cgvs_pkg::AXES; i++) begin
              tgt[i] <= in_data[cgvs_pkg::TGT_LSB + 32*i +: 32];
            end
            idle_ticks <= '0;
          end
          cgvs_pkg::KIND_CONTROL: begin
            idle_ticks <= idle_inc;
            if (idle_inc > cfg.timeout) begin
              for (int i = 0; i < cgvs_pkg::AXES; i++) tgt[i] <= '0;
            end
            // contact onset latches the desired velocity before gating
            if (!prev_contact && in_any) begin
              for (int i = 0; i < cgvs_pkg::AXES; i++) begin
                cause[i] <= in_data[cgvs_pkg::DES_LSB + 32*i +: 32];
              end
            end
            prev_contact <= in_any;
          end
          cgvs_pkg::KIND_START: begin
            for (int i = 0; i < cgvs_pkg::AXES; i++) filt[i] <= '0;
          end
          default: ;
        endcase
      end
      case (cmd.op)
        cgvs_pkg::OP_SUM:  filt[cmd.axis] <= sum_sat;
        cgvs_pkg::OP_STOP: filt[cmd.axis] <= r16_w;
        default: ;
      endcase
      if (cmd.push) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_kind == cgvs_pkg::KIND_CONTROL) begin
      contact <= in_contact;
      collide <= in_data[cgvs_pkg::COLL_BIT];
    end
    case (cmd.op)
      cgvs_pkg::OP_MUL_DECAY, cgvs_pkg::OP_MUL_SCALE: prod <= mul_a * mul_b;
      cgvs_pkg::OP_MUL_GAIN: begin
        prod  <= mul_a * mul_b;
        a_reg <= r16_w;
      end
      cgvs_pkg::OP_CMD:  work[cmd.axis] <= collide ? 32'd0 : cmd_val;
      cgvs_pkg::OP_STOP: work[cmd.axis] <= cmd_val;
      default: ;
    endcase
    if (cmd.push) begin
      out_data <= {work[2], work[1], work[0]};
    end
  end

  assign stat.out_free = !out_valid || out_ready;

endmodule

[rtl/core/contact_gated_velocity_smoother_core.sv]
// Contact-gated three-axis velocity smoother.
// s_* channel: one beat per item, s_tuser carries the kind (target update,
// control tick, stopping tick, start). m_* channel: one beat of cmd_x/y/z for
// each control or stopping tick; updates and starts give no beat.
// cfg_* channel: register writes (index 0 alpha, 1 gain, 2 scale, 3 timeout),
// always ready; write only while no tick is in flight.
// Work: a control tick runs five steps per axis through one shared multiplier
// (decay, gain, sum, scale, output), a stopping tick two per axis (decay,
// stop). A push step then moves the result into the output register and
// raises m_tvalid. s_tready stays low from the tick beat through the push;
// updates and starts leave the core ready for the next item.
// The output register frees the core: the next item is taken while a result
// waits. If the receiver still holds off when the next result is ready, the
// core waits with s_tready low until m_tready.
// Reset (rst, synchronous) clears filter, targets, contact latch, idle
// counter and the output valid, and loads register defaults.
module contact_gated_velocity_smoother_core #(
  parameter int VEL_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // target_x, target_y, target_z, contact_x, contact_y, contact_z, collision,
  // desired_x, desired_y, desired_z, 4 bits zero pad
  input  logic [cgvs_pkg::IN_W-1:0]     s_tdata,
  // kind
  input  logic [1:0]                    s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // cmd_x, cmd_y, cmd_z
  output logic [cgvs_pkg::OUT_W-1:0]    m_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [cgvs_pkg::CFG_W-1:0]    cfg_data
);

  cgvs_pkg::cfg_t     cfg;
  cgvs_pkg::dp_cmd_t  cmd;
  cgvs_pkg::dp_stat_t stat;
  cgvs_pkg::kind_t    kind;

  assign kind      = cgvs_pkg::kind_t'(s_tuser);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.alpha   <= cgvs_pkg::ALPHA_RST;
      cfg.gain    <= cgvs_pkg::GAIN_RST;
      cfg.scale   <= cgvs_pkg::SCALE_RST;
      cfg.timeout <= cgvs_pkg::TIMEOUT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cgvs_pkg::reg_idx_t'(cfg_index))
        cgvs_pkg::REG_ALPHA:   cfg.alpha   <= cfg_data[15:0];
        cgvs_pkg::REG_GAIN:    cfg.gain    <= cfg_data;
        cgvs_pkg::REG_SCALE:   cfg.scale   <= cfg_data[15:0];
        cgvs_pkg::REG_TIMEOUT: cfg.timeout <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  cgvs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (kind),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cgvs_dp #(
    .VEL_WIDTH (VEL_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd       (cmd),
    .in_kind   (kind),
    .in_data   (s_tdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .stat      (stat)
  );

  // a tick beat occupies the core on the next cycle
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (kind == cgvs_pkg::KIND_CONTROL || kind == cgvs_pkg::KIND_STOP))
    |=> !s_tready)
    else $error("core took a tick beat but stayed ready");

  // updates and starts never produce a result, so the core stays free
  a_no_result_free: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (kind == cgvs_pkg::KIND_UPDATE || kind == cgvs_pkg::KIND_START))
    |=> s_tready)
    else $error("core went busy on an update or start beat");

  // a new result only appears as the controller leaves its busy span
  a_result_from_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> ($past(!s_tready) && s_tready))
    else $error("result appeared outside a tick");

  // the controller never pushes over an unread result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.push) |-> (!m_tvalid || m_tready))
    else $error("result overwritten while stalled");

endmodule
